/* sv/rtusf_pkg.sv */
// Shared types, codes and the CRC-16 step for the RTU serial frame controller.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package rtusf_pkg;

    localparam int FRAME_BYTES = 256;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = 8;

    // line states
    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RECV = 3'd2;
    localparam logic [2:0] ST_CTRL = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    // line events
    localparam logic [2:0] CMD_RCVD = 3'd0;
    localparam logic [2:0] CMD_SENT = 3'd1;
    localparam logic [2:0] CMD_ERR  = 3'd2;
    localparam logic [2:0] CMD_T15  = 3'd3;
    localparam logic [2:0] CMD_T35  = 3'd4;

    // UART error kinds
    localparam logic [1:0] ERR_PAR     = 2'd0;
    localparam logic [1:0] ERR_FRAMING = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;

    // flag byte: parity at bit 4, frame_bad at bit 5, overrun at bit 6
    localparam logic [6:0] ERR_CLEAR_MASK = 7'h0f;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [CNT_W-1:0] MIN_FRAME = CNT_W'(3);

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic [1:0] error_kind;
    } t_item;

    typedef struct packed {
        logic             timer_restart;
        logic             store_valid;
        logic [IDX_W-1:0] store_index;
        logic             frame_ready;
        logic [CNT_W-1:0] frame_length;
        logic [7:0]       slave_address;
        logic             emission_done;
        logic             parity_seen;
        logic             overrun_seen;
        logic [2:0]       line_state;
    } t_result;

endpackage

/* sv/rtu_serial_frame_controller_core.sv */
// RTU serial frame controller, top level: input register, line FSM, result register.
// Depends on rtusf_pkg and rtusf_line_fsm.
`timescale 1ns / 1ps

// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one line event per beat:
//   byte received, byte sent, UART error, 1.5- or 3.5-character silence.
//   Output channel (o_out_valid / i_out_ready) carries exactly one result beat
//   per event: timer restart, frame store write, frame verdict, emission done,
//   error latches and the line state after the event.
//   Path: an accepted beat waits in the input register and is moved through the
//   line FSM into the result register once that register is empty or being
//   drained; the result is presented from the result register.
//   Throughput: one event per cycle while i_out_ready stays high; the CRC byte
//   update and the state decision are a single combinational step between the
//   input register and the result register.
//   Reset: the line state returns to init, counters and latches clear and the
//   CRC goes to 0xFFFF; both pipeline registers empty. The silence timer is
//   taken as started by reset.
//   Stall: while i_out_ready is low the result holds; one more event may sit
//   in the input register, after which o_in_ready drops.
module rtu_serial_frame_controller_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_data_byte,
    input  logic [1:0] i_error_kind,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_timer_restart,
    output logic       o_store_valid,
    output logic [7:0] o_store_index,
    output logic       o_frame_ready,
    output logic [8:0] o_frame_length,
    output logic [7:0] o_slave_address,
    output logic       o_emission_done,
    output logic       o_parity_seen,
    output logic       o_overrun_seen,
    output logic [2:0] o_line_state
);

    logic               r_in_valid;
    rtusf_pkg::t_item   r_item;
    logic               r_out_valid;
    rtusf_pkg::t_result r_result;
    rtusf_pkg::t_result fsm_result;
    logic               move;

    // advance when the result slot is empty or being drained this cycle
    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;

    rtusf_line_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (move),
        .i_item   (r_item),
        .o_result (fsm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.command    <= i_command;
            r_item.data_byte  <= i_data_byte;
            r_item.error_kind <= i_error_kind;
        end
        if (move) begin
            r_result <= fsm_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_timer_restart = r_result.timer_restart;
    assign o_store_valid   = r_result.store_valid;
    assign o_store_index   = r_result.store_index;
    assign o_frame_ready   = r_result.frame_ready;
    assign o_frame_length  = r_result.frame_length;
    assign o_slave_address = r_result.slave_address;
    assign o_emission_done = r_result.emission_done;
    assign o_parity_seen   = r_result.parity_seen;
    assign o_overrun_seen  = r_result.overrun_seen;
    assign o_line_state    = r_result.line_state;

endmodule

/* sv/rtusf_crc16.sv */
// One-byte update of the reflected CRC-16 (polynomial 0xA001).
// Depends on rtusf_pkg for the polynomial.
`timescale 1ns / 1ps

module rtusf_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ rtusf_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* sv/rtusf_line_fsm.sv */
// Line-state machine: state, byte count, CRC residue and error latches.
// Depends on rtusf_pkg and rtusf_crc16; updates state on each i_fire beat.
`timescale 1ns / 1ps

module rtusf_line_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rtusf_pkg::t_item  i_item,
    output rtusf_pkg::t_result o_result
);

    localparam int CW = rtusf_pkg::CNT_W;

    logic [2:0]    r_state,    n_state;
    logic          r_bad,      n_bad;
    logic          r_parity,   n_parity;
    logic          r_overrun,  n_overrun;
    logic [CW-1:0] r_count,    n_count;
    logic          r_ovf,      n_ovf;
    logic [15:0]   r_crc,      n_crc;
    logic [7:0]    r_first,    n_first;

    logic [15:0] crc_base;
    logic [15:0] crc_next;
    logic [6:0]  clr_bits;
    logic        is_full;

    // a new frame restarts the CRC from its initial value
    assign crc_base = (r_state == rtusf_pkg::ST_IDLE) ? rtusf_pkg::CRC_INIT : r_crc;

    rtusf_crc16 u_crc (
        .i_crc  (crc_base),
        .i_byte (i_item.data_byte),
        .o_crc  (crc_next)
    );

    assign clr_bits = {r_overrun, r_bad, r_parity, 4'b0000} & rtusf_pkg::ERR_CLEAR_MASK;
    assign is_full  = (r_count >= CW'(rtusf_pkg::FRAME_BYTES));

    always_comb begin
        n_state   = r_state;
        n_bad     = r_bad;
        n_parity  = r_parity;
        n_overrun = r_overrun;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_crc     = r_crc;
        n_first   = r_first;
        o_result  = '0;

        unique case (r_state)
            rtusf_pkg::ST_INIT: begin
                if (i_item.command == rtusf_pkg::CMD_T35) begin
                    n_state = rtusf_pkg::ST_IDLE;
                end else if (i_item.command == rtusf_pkg::CMD_RCVD) begin
                    o_result.timer_restart = 1'b1;
                end else begin
                    n_parity  = clr_bits[4];
                    n_bad     = clr_bits[5];
                    n_overrun = clr_bits[6];
                end
            end
            rtusf_pkg::ST_IDLE: begin
                if (i_item.command == rtusf_pkg::CMD_RCVD) begin
                    n_parity  = clr_bits[4];
                    n_bad     = clr_bits[5];
                    n_overrun = clr_bits[6];
                    n_ovf     = 1'b0;
                    n_crc     = crc_next;
                    n_first   = i_item.data_byte;
                    n_count   = CW'(1);
                    n_state   = rtusf_pkg::ST_RECV;
                    o_result.store_valid   = 1'b1;
                    o_result.timer_restart = 1'b1;
                end else if (i_item.command == rtusf_pkg::CMD_SENT) begin
                    n_state = rtusf_pkg::ST_EMIT;
                    o_result.timer_restart = 1'b1;
                end else begin
                    n_parity  = clr_bits[4];
                    n_bad     = clr_bits[5];
                    n_overrun = clr_bits[6];
                end
            end
            rtusf_pkg::ST_RECV: begin
                if (i_item.command == rtusf_pkg::CMD_RCVD) begin
                    if (!is_full) begin
                        o_result.store_valid = 1'b1;
                        o_result.store_index = r_count[rtusf_pkg::IDX_W-1:0];
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_crc = crc_next;
                    o_result.timer_restart = 1'b1;
                end else if (i_item.command == rtusf_pkg::CMD_T15) begin
                    n_state = rtusf_pkg::ST_CTRL;
                    if (!r_bad && !r_ovf &&
                        (r_count < rtusf_pkg::MIN_FRAME || r_crc != 16'h0000)) begin
                        n_bad = 1'b1;
                    end
                end else if (i_item.command == rtusf_pkg::CMD_ERR) begin
                    if (i_item.error_kind == rtusf_pkg::ERR_PAR)     n_parity  = 1'b1;
                    if (i_item.error_kind == rtusf_pkg::ERR_FRAMING) n_bad     = 1'b1;
                    if (i_item.error_kind == rtusf_pkg::ERR_OVERRUN) n_overrun = 1'b1;
                end
            end
            rtusf_pkg::ST_CTRL: begin
                if (i_item.command == rtusf_pkg::CMD_RCVD) begin
                    // late byte spoils the frame
                    n_bad = 1'b1;
                end else if (i_item.command == rtusf_pkg::CMD_T35) begin
                    n_state = rtusf_pkg::ST_IDLE;
                    if (!r_bad && !r_ovf && r_count >= rtusf_pkg::MIN_FRAME) begin
                        o_result.frame_ready   = 1'b1;
                        o_result.frame_length  = r_count;
                        o_result.slave_address = r_first;
                    end
                end else if (i_item.command == rtusf_pkg::CMD_ERR) begin
                    if (i_item.error_kind == rtusf_pkg::ERR_PAR)     n_parity  = 1'b1;
                    if (i_item.error_kind == rtusf_pkg::ERR_FRAMING) n_bad     = 1'b1;
                    if (i_item.error_kind == rtusf_pkg::ERR_OVERRUN) n_overrun = 1'b1;
                end
            end
            rtusf_pkg::ST_EMIT: begin
                if (i_item.command == rtusf_pkg::CMD_SENT) begin
                    o_result.timer_restart = 1'b1;
                end else if (i_item.command == rtusf_pkg::CMD_T35) begin
                    n_state = rtusf_pkg::ST_IDLE;
                    n_count = '0;
                    o_result.emission_done = 1'b1;
                end else if (i_item.command == rtusf_pkg::CMD_ERR) begin
                    if (i_item.error_kind == rtusf_pkg::ERR_PAR)     n_parity  = 1'b1;
                    if (i_item.error_kind == rtusf_pkg::ERR_FRAMING) n_bad     = 1'b1;
                    if (i_item.error_kind == rtusf_pkg::ERR_OVERRUN) n_overrun = 1'b1;
                end
            end
            default: begin
                n_state = rtusf_pkg::ST_INIT;
            end
        endcase

        o_result.parity_seen  = n_parity;
        o_result.overrun_seen = n_overrun;
        o_result.line_state   = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rtusf_pkg::ST_INIT;
            r_bad     <= 1'b0;
            r_parity  <= 1'b0;
            r_overrun <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_crc     <= rtusf_pkg::CRC_INIT;
            r_first   <= 8'h00;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_bad     <= n_bad;
            r_parity  <= n_parity;
            r_overrun <= n_overrun;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_crc     <= n_crc;
            r_first   <= n_first;
        end
    end

endmodule

/* sim/rtu_serial_frame_controller_core_tb.sv */
// Self-checking testbench for rtu_serial_frame_controller_core: line events in, one result beat out.
// Predicts every result with its own line FSM and CRC-16; uses codes and types from rtusf_pkg.
`timescale 1ns / 1ps

module rtu_serial_frame_controller_core_tb;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RST_CYCLES   = 2;
    localparam int DRAIN_CYCLES = 10;
    localparam int RAND_EVENTS  = 1500;
    localparam int MAX_PRINTS   = 40;

    // commands with no meaning, and the ignored UART error kind
    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;
    localparam logic [1:0] ERR_OTHER   = 2'd3;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [2:0] i_command    = rtusf_pkg::CMD_T15;
    logic [7:0] i_data_byte  = 8'h00;
    logic [1:0] i_error_kind = rtusf_pkg::ERR_PAR;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic       o_timer_restart;
    logic       o_store_valid;
    logic [7:0] o_store_index;
    logic       o_frame_ready;
    logic [8:0] o_frame_length;
    logic [7:0] o_slave_address;
    logic       o_emission_done;
    logic       o_parity_seen;
    logic       o_overrun_seen;
    logic [2:0] o_line_state;

    rtu_serial_frame_controller_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .i_error_kind    (i_error_kind),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_timer_restart (o_timer_restart),
        .o_store_valid   (o_store_valid),
        .o_store_index   (o_store_index),
        .o_frame_ready   (o_frame_ready),
        .o_frame_length  (o_frame_length),
        .o_slave_address (o_slave_address),
        .o_emission_done (o_emission_done),
        .o_parity_seen   (o_parity_seen),
        .o_overrun_seen  (o_overrun_seen),
        .o_line_state    (o_line_state)
    );

    always #5 i_clk = ~i_clk;

    rtusf_pkg::t_item   line_ev_q[$];
    rtusf_pkg::t_result line_result_q[$];

    int cycles    = 0;
    int fail_cnt  = 0;
    int queued    = 0;
    int rst_cnt   = 0;
    int tx_gap    = 0;
    int rx_hold   = 0;
    int phase_left = 0;
    bit calm      = 1'b0;
    bit in_took   = 1'b0;

    // predicted line state, latches, count and CRC
    logic [2:0]  ln_state  = rtusf_pkg::ST_INIT;
    logic        bad       = 1'b0;
    logic        par       = 1'b0;
    logic        ovr       = 1'b0;
    logic [8:0]  cnt       = '0;
    logic        ovf       = 1'b0;
    logic [15:0] crc       = rtusf_pkg::CRC_INIT;
    logic [7:0]  addr0     = 8'h00;

    function automatic logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            v = v[0] ? ((v >> 1) ^ rtusf_pkg::CRC_POLY) : (v >> 1);
        return v;
    endfunction

    function automatic void latch_uart_error(logic [1:0] kind);
        if (kind == rtusf_pkg::ERR_PAR) par = 1'b1;
        else if (kind == rtusf_pkg::ERR_FRAMING) bad = 1'b1;
        else if (kind == rtusf_pkg::ERR_OVERRUN) ovr = 1'b1;
    endfunction

    function automatic rtusf_pkg::t_result step_line_fsm(rtusf_pkg::t_item ev);
        rtusf_pkg::t_result r;
        r = '0;
        case (ln_state)
            rtusf_pkg::ST_INIT: begin
                if (ev.command == rtusf_pkg::CMD_T35) ln_state = rtusf_pkg::ST_IDLE;
                else if (ev.command == rtusf_pkg::CMD_RCVD) r.timer_restart = 1'b1;
                else begin
                    par = 1'b0; bad = 1'b0; ovr = 1'b0;
                end
            end
            rtusf_pkg::ST_IDLE: begin
                if (ev.command == rtusf_pkg::CMD_RCVD) begin
                    par = 1'b0; bad = 1'b0; ovr = 1'b0;
                    ovf = 1'b0;
                    crc = crc16_byte(rtusf_pkg::CRC_INIT, ev.data_byte);
                    addr0 = ev.data_byte;
                    r.store_valid = 1'b1;
                    r.store_index = '0;
                    cnt = 9'd1;
                    ln_state = rtusf_pkg::ST_RECV;
                    r.timer_restart = 1'b1;
                end else if (ev.command == rtusf_pkg::CMD_SENT) begin
                    ln_state = rtusf_pkg::ST_EMIT;
                    r.timer_restart = 1'b1;
                end else begin
                    par = 1'b0; bad = 1'b0; ovr = 1'b0;
                end
            end
            rtusf_pkg::ST_RECV: begin
                if (ev.command == rtusf_pkg::CMD_RCVD) begin
                    // store full: hold the count and flag the overflow
                    if (cnt < rtusf_pkg::FRAME_BYTES) begin
                        r.store_valid = 1'b1;
                        r.store_index = cnt[7:0];
                        cnt = cnt + 9'd1;
                    end else begin
                        ovf = 1'b1;
                    end
                    crc = crc16_byte(crc, ev.data_byte);
                    r.timer_restart = 1'b1;
                end else if (ev.command == rtusf_pkg::CMD_T15) begin
                    ln_state = rtusf_pkg::ST_CTRL;
                    if (!bad && !ovf && (cnt < rtusf_pkg::MIN_FRAME || crc != 16'h0000))
                        bad = 1'b1;
                end else if (ev.command == rtusf_pkg::CMD_ERR) begin
                    latch_uart_error(ev.error_kind);
                end
            end
            rtusf_pkg::ST_CTRL: begin
                if (ev.command == rtusf_pkg::CMD_RCVD) begin
                    bad = 1'b1;
                end else if (ev.command == rtusf_pkg::CMD_T35) begin
                    ln_state = rtusf_pkg::ST_IDLE;
                    if (!bad && !ovf && cnt >= rtusf_pkg::MIN_FRAME) begin
                        r.frame_ready   = 1'b1;
                        r.frame_length  = cnt;
                        r.slave_address = addr0;
                    end
                end else if (ev.command == rtusf_pkg::CMD_ERR) begin
                    latch_uart_error(ev.error_kind);
                end
            end
            rtusf_pkg::ST_EMIT: begin
                if (ev.command == rtusf_pkg::CMD_SENT) begin
                    r.timer_restart = 1'b1;
                end else if (ev.command == rtusf_pkg::CMD_T35) begin
                    ln_state = rtusf_pkg::ST_IDLE;
                    cnt = '0;
                    r.emission_done = 1'b1;
                end else if (ev.command == rtusf_pkg::CMD_ERR) begin
                    latch_uart_error(ev.error_kind);
                end
            end
            default: ln_state = rtusf_pkg::ST_INIT;
        endcase
        r.parity_seen  = par;
        r.overrun_seen = ovr;
        r.line_state   = ln_state;
        return r;
    endfunction

    task automatic report(string msg);
        fail_cnt++;
        if (fail_cnt <= MAX_PRINTS)
            $display("cycle %0d: %s", cycles, msg);
    endtask

    task automatic chk(string field, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
    endtask

    task automatic put_event(logic [2:0] cmd, logic [7:0] db, logic [1:0] ek);
        rtusf_pkg::t_item ev;
        ev.command    = cmd;
        ev.data_byte  = db;
        ev.error_kind = ek;
        line_ev_q.push_back(ev);
        queued++;
    endtask

    // Frame bytes, optional valid CRC and UART errors, then T1.5 unless skipped, optional late byte, T3.5.
    task automatic push_frame(int nbytes, bit good, bit noisy, bit late, bit skip_t15);
        logic [7:0]  body[$];
        logic [15:0] c;
        int          n_pay;
        n_pay = (good && nbytes >= 3) ? nbytes - 2 : nbytes;
        c = rtusf_pkg::CRC_INIT;
        for (int i = 0; i < n_pay; i++) begin
            body.push_back(8'($urandom));
            c = crc16_byte(c, body[i]);
        end
        if (n_pay != nbytes) begin
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
        end
        foreach (body[i]) begin
            put_event(rtusf_pkg::CMD_RCVD, body[i], 2'($urandom));
            if (noisy && $urandom_range(0, 5) == 0)
                put_event(rtusf_pkg::CMD_ERR, 8'($urandom), 2'($urandom));
        end
        if (!skip_t15) put_event(rtusf_pkg::CMD_T15, 8'($urandom), 2'($urandom));
        if (late) put_event(rtusf_pkg::CMD_RCVD, 8'($urandom), 2'($urandom));
        put_event(rtusf_pkg::CMD_T35, 8'($urandom), 2'($urandom));
    endtask

    function automatic int idle_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver: reset, event beats and result backpressure, all at the falling edge.
    always @(negedge i_clk) begin : drive
        rtusf_pkg::t_item nxt;
        if (phase_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(50, 400);
        end else begin
            phase_left--;
        end
        if (rst_cnt < RST_CYCLES) begin
            rst_cnt++;
            if (rst_cnt == RST_CYCLES) i_rst_n <= 1'b1;
        end else begin
            if (!i_in_valid || in_took) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (line_ev_q.size() > 0) begin
                    nxt = line_ev_q.pop_front();
                    i_command    <= nxt.command;
                    i_data_byte  <= nxt.data_byte;
                    i_error_kind <= nxt.error_kind;
                    i_in_valid   <= 1'b1;
                    tx_gap = idle_len(calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) rx_hold = idle_len(calm);
            end
        end
    end

    // Monitor: predict on each accepted event beat, check each accepted result beat.
    always @(posedge i_clk) begin : watch
        rtusf_pkg::t_result w;
        rtusf_pkg::t_item   ev;
        cycles++;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (line_result_q.size() == 0) begin
                    report("result beat with no event pending");
                end else begin
                    w = line_result_q.pop_front();
                    chk("timer_restart", o_timer_restart, w.timer_restart);
                    chk("store_valid",   o_store_valid,   w.store_valid);
                    chk("store_index",   o_store_index,   w.store_index);
                    chk("frame_ready",   o_frame_ready,   w.frame_ready);
                    chk("frame_length",  o_frame_length,  w.frame_length);
                    chk("slave_address", o_slave_address, w.slave_address);
                    chk("emission_done", o_emission_done, w.emission_done);
                    chk("parity_seen",   o_parity_seen,   w.parity_seen);
                    chk("overrun_seen",  o_overrun_seen,  w.overrun_seen);
                    chk("line_state",    o_line_state,    w.line_state);
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_took = 1'b1;
                ev.command    = i_command;
                ev.data_byte  = i_data_byte;
                ev.error_kind = i_error_kind;
                line_result_q.push_back(step_line_fsm(ev));
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL rtu_serial_frame_controller_core");
            $finish;
        end
    end

    initial begin : stim
        logic [15:0] c;
        int          pick;
        int          len;
        bit          dirty;
        bit          skip;
        bit          big_done;
        bit          ovf_done;
        dirty    = 1'b0;
        big_done = 1'b0;
        ovf_done = 1'b0;

        // init: byte restarts the timer, errors and a reserved command clear, T3.5 goes to idle
        put_event(rtusf_pkg::CMD_RCVD, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_ERR, 8'hFF, rtusf_pkg::ERR_PAR);
        put_event(CMD_RSVD_HI, 8'hFF, ERR_OTHER);
        put_event(rtusf_pkg::CMD_T35, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_ERR, 8'h00, rtusf_pkg::ERR_FRAMING);
        // good frame, address 0xFF
        c = crc16_byte(crc16_byte(rtusf_pkg::CRC_INIT, 8'hFF), 8'h00);
        put_event(rtusf_pkg::CMD_RCVD, 8'hFF, ERR_OTHER);
        put_event(rtusf_pkg::CMD_RCVD, 8'h00, ERR_OTHER);
        put_event(rtusf_pkg::CMD_RCVD, c[7:0], ERR_OTHER);
        put_event(rtusf_pkg::CMD_RCVD, c[15:8], ERR_OTHER);
        put_event(rtusf_pkg::CMD_T15, 8'hFF, ERR_OTHER);
        put_event(rtusf_pkg::CMD_T35, 8'hFF, ERR_OTHER);
        // short frame
        put_event(rtusf_pkg::CMD_RCVD, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_RCVD, 8'hFF, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_T15, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_T35, 8'h00, rtusf_pkg::ERR_PAR);
        // errors during reception, an out-of-place T3.5, a late byte
        put_event(rtusf_pkg::CMD_RCVD, 8'hA5, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_ERR, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_ERR, 8'h00, rtusf_pkg::ERR_OVERRUN);
        put_event(rtusf_pkg::CMD_ERR, 8'h00, ERR_OTHER);
        put_event(rtusf_pkg::CMD_RCVD, 8'h5A, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_T35, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(CMD_RSVD_LO, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_T15, 8'h00, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_RCVD, 8'h3C, rtusf_pkg::ERR_PAR);
        put_event(rtusf_pkg::CMD_ERR, 8'h00, rtusf_pkg::ERR_FRAMING);
        put_event(rtusf_pkg::CMD_T35, 8'h00, rtusf_pkg::ERR_PAR);
        // emission
        put_event(rtusf_pkg::CMD_SENT, 8'hFF, ERR_OTHER);
        put_event(rtusf_pkg::CMD_SENT, 8'h00, ERR_OTHER);
        put_event(rtusf_pkg::CMD_ERR, 8'h00, rtusf_pkg::ERR_OVERRUN);
        put_event(rtusf_pkg::CMD_T35, 8'hFF, ERR_OTHER);

        while (queued < RAND_EVENTS) begin
            // T1.5 then T3.5 brings any line state back to idle
            if (dirty) begin
                put_event(rtusf_pkg::CMD_T15, 8'($urandom), 2'($urandom));
                put_event(rtusf_pkg::CMD_T35, 8'($urandom), 2'($urandom));
                dirty = 1'b0;
            end
            if (!big_done && queued > 500) begin
                push_frame(rtusf_pkg::FRAME_BYTES, 1'b1, 1'b0, 1'b0, 1'b0);
                big_done = 1'b1;
            end else if (!ovf_done && queued > 1000) begin
                push_frame(rtusf_pkg::FRAME_BYTES + 1, 1'b1, 1'b0, 1'b0, 1'b0);
                ovf_done = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    len = $urandom_range(0, 9);
                    if (len == 0) len = $urandom_range(1, 2);
                    else if (len < 8) len = $urandom_range(3, 8);
                    else len = $urandom_range(9, 24);
                    skip = ($urandom_range(0, 19) == 0);
                    push_frame(len, $urandom_range(0, 4) != 0, $urandom_range(0, 5) == 0,
                               $urandom_range(0, 9) == 0, skip);
                    dirty = skip;
                end else if (pick < 80) begin
                    repeat ($urandom_range(1, 6)) begin
                        put_event(rtusf_pkg::CMD_SENT, 8'($urandom), 2'($urandom));
                        if ($urandom_range(0, 4) == 0)
                            put_event(rtusf_pkg::CMD_ERR, 8'($urandom), 2'($urandom));
                    end
                    put_event(rtusf_pkg::CMD_T35, 8'($urandom), 2'($urandom));
                end else begin
                    repeat ($urandom_range(1, 4))
                        put_event(3'($urandom_range(rtusf_pkg::CMD_RCVD, CMD_RSVD_HI)),
                                  8'($urandom), 2'($urandom));
                    dirty = 1'b1;
                end
            end
        end

        while (line_ev_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (line_result_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS rtu_serial_frame_controller_core");
        end else begin
            $display("FAIL rtu_serial_frame_controller_core");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/rtusf_pkg.sv
sv/rtusf_crc16.sv
sv/rtusf_line_fsm.sv
sv/rtu_serial_frame_controller_core.sv
sim/rtu_serial_frame_controller_core_tb.sv
